// ----- hdl/centronics_printer_port_assert.svh -----
// Assertion macros shared by the printer port modules.
`ifndef CENTRONICS_PRINTER_PORT_ASSERT_SVH
`define CENTRONICS_PRINTER_PORT_ASSERT_SVH

`ifndef SYNTH

`define CPP_ASSERT_ALW(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

`define CPP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define CPP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CPP_ASSERT_ALW(lbl, clk, rst, cond)
`define CPP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CPP_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/cpp_pkg.sv -----
// Types, constants and codes for the printer port.
`timescale 1ns / 1ps

package cpp_pkg;

  localparam int BUF_DEPTH = 4096;
  localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int FILL_W    = $clog2(BUF_DEPTH + 1);
  localparam int DROP_W    = 32;
  localparam int DUR_W     = 20;
  localparam int TIME_W    = 64;
  localparam int BYTE_W    = 8;
  localparam int CMD_W     = 3;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int S_DATA_W  = 80;
  localparam int M_DATA_W  = 64;

  // command codes
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WR_CTRL  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WR_DATA  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ONLINE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TAKE_IRQ = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_TIME     = 3'd6;

  // register index (paddr bit 2)
  localparam logic REG_BUSY_DUR = 1'b0;
  localparam logic REG_ACK_DUR  = 1'b1;

  localparam logic [DUR_W-1:0]  BUSY_DUR_RESET = 20'd1000;
  localparam logic [DUR_W-1:0]  ACK_DUR_RESET  = 20'd100;
  localparam logic [BYTE_W-1:0] DATA_RESET     = 8'hFF;
  localparam logic [BYTE_W-1:0] STAT_FIXED     = 8'h0C;
  localparam logic [BYTE_W-1:0] STAT_ACK       = 8'h02;
  localparam logic [BYTE_W-1:0] STAT_BUSY      = 8'h01;
  localparam int                CTL_STB_BIT    = 7;
  localparam int                CTL_PRIM_BIT   = 6;
  localparam logic [DROP_W-1:0] DROP_MAX       = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RETIRE_BUSY,
    S_RETIRE_ACK,
    S_EXEC,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic              retire_busy;
    logic              retire_ack;
    logic              exec;
    logic              finish;
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] now;
    logic [BYTE_W-1:0] wv;
    logic              level;
  } hs_ctrl_t;

  typedef struct packed {
    logic              strobe;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] rd;
    logic              irq_out;
  } hs_res_t;

endpackage

// ----- hdl/centronics_printer_port.sv -----
// A command accepted in S_IDLE is sequenced through S_RETIRE_BUSY, S_RETIRE_ACK, S_EXEC and
// S_FINISH, which loads its result into m_tdata once m_tvalid is low or m_tready is high. A new
// command is taken only back in S_IDLE, after the BUSY retire, ACK retire, execute and ACK deadline add.
// The result register frees the input side while a result waits on m_tready.
// Reset: synchronous, active high; sequencer, handshake, counters and m_tvalid return to reset values,
// the capture memory is not cleared (the fill count covers it), nor are the item and result registers.
`timescale 1ns / 1ps

module centronics_printer_port (
  input  logic                         clk,
  input  logic                         rst,
  // slave stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [63:0] time_now, [71:64] write_value, [72] online_level, [79:73] zero
  input  logic [cpp_pkg::S_DATA_W-1:0] s_tdata,
  // [2:0] cmd
  input  logic [cpp_pkg::CMD_W-1:0]    s_tuser,
  // master stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [7:0] read_value, [8] interrupt_taken, [9] byte_accepted, [17:10] accepted_byte,
  // [30:18] buffer_fill, [62:31] dropped_total, [63] output_dirty
  output logic [cpp_pkg::M_DATA_W-1:0] m_tdata,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cpp_pkg::APB_AW-1:0]   paddr,
  input  logic [cpp_pkg::APB_DW-1:0]   pwdata,
  output logic [cpp_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import cpp_pkg::*;

  state_t            state;
  state_t            state_next;

  logic [CMD_W-1:0]  item_cmd;
  logic [TIME_W-1:0] item_time;
  logic [BYTE_W-1:0] item_wv;
  logic              item_level;

  logic [DUR_W-1:0]  busy_dur;
  logic [DUR_W-1:0]  ack_dur;

  logic [BYTE_W-1:0] res_rd;
  logic              res_irq;
  logic              res_acc;
  logic [BYTE_W-1:0] res_byte;

  hs_ctrl_t          hs_ctrl;
  hs_res_t           hs_res;
  logic              load_out;
  logic              clear;

  logic [FILL_W-1:0] fill;
  logic [DROP_W-1:0] dropped;
  logic              dirty;

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_BUSY_DUR: prdata = APB_DW'(busy_dur);
      REG_ACK_DUR:  prdata = APB_DW'(ack_dur);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_dur <= BUSY_DUR_RESET;
      ack_dur  <= ACK_DUR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_BUSY_DUR: busy_dur <= pwdata[DUR_W-1:0];
        REG_ACK_DUR:  ack_dur  <= pwdata[DUR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next          = state;
    s_tready            = 1'b0;
    load_out            = 1'b0;
    hs_ctrl.retire_busy = 1'b0;
    hs_ctrl.retire_ack  = 1'b0;
    hs_ctrl.exec        = 1'b0;
    hs_ctrl.finish      = 1'b0;
    hs_ctrl.cmd         = item_cmd;
    hs_ctrl.now         = item_time;
    hs_ctrl.wv          = item_wv;
    hs_ctrl.level       = item_level;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = S_RETIRE_BUSY;
        end
      end
      S_RETIRE_BUSY: begin
        hs_ctrl.retire_busy = 1'b1;
        state_next          = S_RETIRE_ACK;
      end
      S_RETIRE_ACK: begin
        hs_ctrl.retire_ack = 1'b1;
        state_next         = S_EXEC;
      end
      S_EXEC: begin
        hs_ctrl.exec = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        hs_ctrl.finish = 1'b1;
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign clear = hs_ctrl.exec && (item_cmd == CMD_CLEAR);

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_cmd   <= s_tuser;
      item_time  <= s_tdata[TIME_W-1:0];
      item_wv    <= s_tdata[TIME_W +: BYTE_W];
      item_level <= s_tdata[TIME_W + BYTE_W];
    end
    if (hs_ctrl.exec) begin
      res_rd   <= hs_res.rd;
      res_irq  <= hs_res.irq_out;
      res_acc  <= hs_res.strobe;
      res_byte <= hs_res.data_byte;
    end
    if (load_out) begin
      m_tdata <= {dirty, dropped, fill, res_byte, res_acc, res_irq, res_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  cpp_handshake u_handshake (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (hs_ctrl),
    .busy_dur (busy_dur),
    .ack_dur  (ack_dur),
    .res      (hs_res)
  );

  cpp_capture u_capture (
    .clk     (clk),
    .rst     (rst),
    .capture (hs_res.strobe),
    .clear   (clear),
    .data_in (hs_res.data_byte),
    .fill    (fill),
    .dropped (dropped),
    .dirty   (dirty)
  );

  `include "centronics_printer_port_assert.svh"

  `CPP_ASSERT_IMP(a_out_from_finish, clk, rst, $rose(m_tvalid), $past(state == S_FINISH))
  `CPP_ASSERT_NXT(a_accept_starts, clk, rst, s_tvalid && s_tready, state == S_RETIRE_BUSY)
  `CPP_ASSERT_IMP(a_strobe_in_exec, clk, rst, hs_res.strobe, state == S_EXEC)

endmodule

// ----- hdl/cpp_handshake.sv -----
// Control/data latches, BUSY/ACK handshake and deadline tracking.
`timescale 1ns / 1ps

module cpp_handshake (
  input  logic                      clk,
  input  logic                      rst,
  input  cpp_pkg::hs_ctrl_t         ctrl,
  input  logic [cpp_pkg::DUR_W-1:0] busy_dur,
  input  logic [cpp_pkg::DUR_W-1:0] ack_dur,
  output cpp_pkg::hs_res_t          res
);
  import cpp_pkg::*;

  logic              ctl_stb;
  logic              ctl_prim;
  logic [BYTE_W-1:0] data_latch;
  logic              busy;
  logic              ack_high;
  logic              irq;
  logic              online;
  logic              arm_ack;
  logic [TIME_W-1:0] busy_dl;
  logic [TIME_W-1:0] ack_dl;

  logic retire_en;
  logic busy_due;
  logic ack_due;
  logic prim_fall;
  logic stb_fall;
  logic strobe;

  assign retire_en = (ctrl.cmd == CMD_READ) || (ctrl.cmd == CMD_WR_CTRL) ||
                     (ctrl.cmd == CMD_WR_DATA) || (ctrl.cmd == CMD_ONLINE) ||
                     (ctrl.cmd == CMD_TIME);
  assign busy_due  = busy && (ctrl.now >= busy_dl);
  assign ack_due   = !ack_high && (ctrl.now >= ack_dl);
  assign prim_fall = ctl_prim && !ctrl.wv[CTL_PRIM_BIT];
  assign stb_fall  = ctl_stb && !ctrl.wv[CTL_STB_BIT] && ctrl.wv[CTL_PRIM_BIT] &&
                     online && !busy;
  assign strobe    = ctrl.exec && (ctrl.cmd == CMD_WR_CTRL) && !prim_fall && stb_fall;

  always_comb begin
    res.strobe    = strobe;
    res.data_byte = strobe ? data_latch : '0;
    res.rd        = '0;
    res.irq_out   = 1'b0;
    if (ctrl.cmd == CMD_READ) begin
      res.rd = {ctl_stb, ctl_prim, 6'b0} | STAT_FIXED |
               (ack_high ? STAT_ACK : '0) |
               ((busy || !online) ? STAT_BUSY : '0);
    end
    if (ctrl.cmd == CMD_TAKE_IRQ) begin
      res.irq_out = irq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_stb    <= 1'b1;
      ctl_prim   <= 1'b1;
      data_latch <= DATA_RESET;
      busy       <= 1'b0;
      ack_high   <= 1'b1;
      irq        <= 1'b0;
      online     <= 1'b1;
      arm_ack    <= 1'b0;
      busy_dl    <= '0;
      ack_dl     <= '0;
    end else if (ctrl.retire_busy) begin
      if (retire_en && busy_due) begin
        busy     <= 1'b0;
        ack_high <= 1'b0;
        ack_dl   <= busy_dl + TIME_W'(ack_dur);
        irq      <= 1'b1;
      end
    end else if (ctrl.retire_ack) begin
      if (retire_en && ack_due) begin
        ack_high <= 1'b1;
      end
    end else if (ctrl.exec) begin
      arm_ack <= strobe;
      case (ctrl.cmd)
        CMD_WR_CTRL: begin
          ctl_stb  <= ctrl.wv[CTL_STB_BIT];
          ctl_prim <= ctrl.wv[CTL_PRIM_BIT];
          if (prim_fall) begin
            busy     <= 1'b0;
            ack_high <= 1'b1;
            irq      <= 1'b0;
            busy_dl  <= ctrl.now;
            ack_dl   <= ctrl.now;
          end else if (stb_fall) begin
            busy     <= 1'b1;
            ack_high <= 1'b1;
            irq      <= 1'b0;
            busy_dl  <= ctrl.now + TIME_W'(busy_dur);
          end
        end
        CMD_WR_DATA: begin
          data_latch <= ctrl.wv;
        end
        CMD_ONLINE: begin
          online <= ctrl.level;
          if (!ctrl.level) begin
            busy     <= 1'b0;
            ack_high <= 1'b1;
            irq      <= 1'b0;
          end
        end
        CMD_TAKE_IRQ: begin
          irq <= 1'b0;
        end
        default: begin
        end
      endcase
    end else if (ctrl.finish) begin
      // second add of a strobe: ACK deadline follows the new BUSY deadline
      if (arm_ack) begin
        ack_dl <= busy_dl + TIME_W'(ack_dur);
      end
    end
  end

  `include "centronics_printer_port_assert.svh"

  `CPP_ASSERT_ALW(a_busy_ack_high, clk, rst, !busy || ack_high)
  `CPP_ASSERT_IMP(a_irq_rise, clk, rst, $rose(irq), $past(ctrl.retire_busy))
  `CPP_ASSERT_IMP(a_strobe_sets_busy, clk, rst, $past(strobe), busy && !irq)

endmodule

// ----- hdl/cpp_capture.sv -----
// Capture buffer memory with fill count, drop counter and dirty flag.
`timescale 1ns / 1ps

module cpp_capture (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       capture,
  input  logic                       clear,
  input  logic [cpp_pkg::BYTE_W-1:0] data_in,
  output logic [cpp_pkg::FILL_W-1:0] fill,
  output logic [cpp_pkg::DROP_W-1:0] dropped,
  output logic                       dirty
);
  import cpp_pkg::*;

  logic [BYTE_W-1:0] mem [BUF_DEPTH];
  logic [FILL_W-1:0] count;
  logic [DROP_W-1:0] drops;
  logic              dirty_q;
  logic              has_room;
  logic              we;

  // readback of the last written entry, checked below
  logic              wr_q;
  logic [BUF_AW-1:0] wr_addr_q;
  logic [BYTE_W-1:0] wr_byte_q;
  logic              chk_q;
  logic [BYTE_W-1:0] exp_q;
  logic [BYTE_W-1:0] rd_data;

  assign has_room = count < FILL_W'(BUF_DEPTH);
  assign we       = capture && !clear && has_room;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[count[BUF_AW-1:0]] <= data_in;
    end
    rd_data <= mem[wr_addr_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      drops   <= '0;
      dirty_q <= 1'b0;
      wr_q    <= 1'b0;
      chk_q   <= 1'b0;
    end else begin
      wr_q  <= we;
      chk_q <= wr_q;
      if (clear) begin
        count   <= '0;
        drops   <= '0;
        dirty_q <= 1'b0;
      end else if (capture) begin
        dirty_q <= 1'b1;
        if (has_room) begin
          count <= count + 1'b1;
        end else if (drops != DROP_MAX) begin
          drops <= drops + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      wr_addr_q <= count[BUF_AW-1:0];
      wr_byte_q <= data_in;
    end
    exp_q <= wr_byte_q;
  end

  assign fill    = count;
  assign dropped = drops;
  assign dirty   = dirty_q;

  `include "centronics_printer_port_assert.svh"

  `CPP_ASSERT_ALW(a_fill_bound, clk, rst, count <= FILL_W'(BUF_DEPTH))
  `CPP_ASSERT_IMP(a_dirty_fall, clk, rst, $fell(dirty_q), $past(clear) || $past(rst))
  `CPP_ASSERT_IMP(a_readback, clk, rst, chk_q, rd_data == exp_q)

endmodule

// ----- dv/centronics_printer_port_tb.sv -----
// Self-checking testbench for the Centronics printer port: stream commands, APB durations.
`timescale 1ns / 1ps

module centronics_printer_port_tb;
  import cpp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 625;
  localparam int MIN_DROPS   = 40;

  typedef struct packed {
    logic              dirty;
    logic [DROP_W-1:0] drops;
    logic [FILL_W-1:0] fill;
    logic [BYTE_W-1:0] abyte;
    logic              acc;
    logic              irq;
    logic [BYTE_W-1:0] status;
  } port_resp_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] t;
    logic [BYTE_W-1:0] wv;
    logic              lvl;
  } printer_cmd_t;

  typedef struct {
    printer_cmd_t      c;
    bit                lit;
    logic [BYTE_W-1:0] lit_status;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [CMD_W-1:0]    s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  centronics_printer_port DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // port state as the host sees it
  logic [DUR_W-1:0]  dur_busy = BUSY_DUR_RESET;
  logic [DUR_W-1:0]  dur_ack  = ACK_DUR_RESET;
  logic [BYTE_W-1:0] ctl_q    = 8'hC0;
  logic [BYTE_W-1:0] data_q   = DATA_RESET;
  logic              busy_q   = 1'b0;
  logic              ack_hi_q = 1'b1;
  logic              irq_q    = 1'b0;
  logic              online_q = 1'b1;
  logic [TIME_W-1:0] busy_dl  = '0;
  logic [TIME_W-1:0] ack_dl   = '0;
  logic [FILL_W-1:0] fill_q   = '0;
  logic [DROP_W-1:0] drop_q   = '0;
  logic              dirty_q  = 1'b0;

  port_resp_t        response_q[$];
  stim_row_t         stim_table[$];
  logic [TIME_W-1:0] clock_now = '0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int n_random = 0;
  int n_checked = 0;
  int n_mismatch = 0;
  int n_unexpected = 0;
  int n_strobes = 0;
  int n_drops = 0;
  int n_irqs = 0;
  int cycles = 0;

  function automatic port_resp_t predict_port(printer_cmd_t c);
    port_resp_t r;
    logic old_stb, old_prim;
    r = '0;
    if (c.cmd <= CMD_ONLINE || c.cmd == CMD_TIME) begin
      if (busy_q && c.t >= busy_dl) begin
        busy_q   = 1'b0;
        ack_hi_q = 1'b0;
        ack_dl   = busy_dl + TIME_W'(dur_ack);
        irq_q    = 1'b1;
      end
      if (!ack_hi_q && c.t >= ack_dl) ack_hi_q = 1'b1;
    end
    case (c.cmd)
      CMD_READ: begin
        r.status = {ctl_q[7:6], 6'b0} | STAT_FIXED | (ack_hi_q ? STAT_ACK : 8'h00) |
                   ((busy_q || !online_q) ? STAT_BUSY : 8'h00);
      end
      CMD_WR_CTRL: begin
        old_stb  = ctl_q[CTL_STB_BIT];
        old_prim = ctl_q[CTL_PRIM_BIT];
        ctl_q    = {c.wv[7:6], 6'b0};
        if (old_prim && !ctl_q[CTL_PRIM_BIT]) begin
          busy_q   = 1'b0;
          ack_hi_q = 1'b1;
          irq_q    = 1'b0;
          busy_dl  = c.t;
          ack_dl   = c.t;
        end else if (old_stb && !ctl_q[CTL_STB_BIT] && ctl_q[CTL_PRIM_BIT] && online_q &&
                     !busy_q) begin
          // saturation of the drop count needs 2^32 drops, out of reach here
          if (fill_q < BUF_DEPTH) begin
            fill_q = fill_q + 1'b1;
          end else if (drop_q != DROP_MAX) begin
            drop_q = drop_q + 1'b1;
            n_drops++;
          end
          r.acc    = 1'b1;
          r.abyte  = data_q;
          dirty_q  = 1'b1;
          busy_q   = 1'b1;
          ack_hi_q = 1'b1;
          irq_q    = 1'b0;
          busy_dl  = c.t + TIME_W'(dur_busy);
          ack_dl   = busy_dl + TIME_W'(dur_ack);
          n_strobes++;
        end
      end
      CMD_WR_DATA: data_q = c.wv;
      CMD_ONLINE: begin
        online_q = c.lvl;
        if (!online_q) begin
          busy_q   = 1'b0;
          ack_hi_q = 1'b1;
          irq_q    = 1'b0;
        end
      end
      CMD_TAKE_IRQ: begin
        r.irq = irq_q;
        if (irq_q) n_irqs++;
        irq_q = 1'b0;
      end
      CMD_CLEAR: begin
        fill_q  = '0;
        drop_q  = '0;
        dirty_q = 1'b0;
      end
      default: ;
    endcase
    r.fill  = fill_q;
    r.drops = drop_q;
    r.dirty = dirty_q;
    return r;
  endfunction

  function automatic string fmt_resp(port_resp_t r);
    return $sformatf("st=%h irq=%b acc=%b byte=%h fill=%0d drop=%0d dirty=%b",
                     r.status, r.irq, r.acc, r.abyte, r.fill, r.drops, r.dirty);
  endfunction

  // mostly small steps, some past both deadlines, rare random jumps and steps back
  function automatic logic [TIME_W-1:0] next_time();
    logic [31:0] span;
    span = 32'(dur_busy) + 32'(dur_ack) + 1;
    case ($urandom_range(39))
      0: clock_now = {$urandom, $urandom};
      1: clock_now = (clock_now > 3000) ? clock_now - $urandom_range(3000) : '0;
      2, 3: clock_now = clock_now + span + $urandom_range(100);
      default: begin
        if ($urandom_range(1)) clock_now = clock_now + $urandom_range(15);
        else clock_now = clock_now + $urandom_range(span >> 2);
      end
    endcase
    return clock_now;
  endfunction

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
                       input logic [BYTE_W-1:0] wv, input logic lvl,
                       input bit lit, input logic [BYTE_W-1:0] lit_status);
    printer_cmd_t c;
    port_resp_t r;
    c.cmd = cmd;
    c.t   = t;
    c.wv  = wv;
    c.lvl = lvl;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, lvl, wv, t};
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = predict_port(c);
    if (lit) begin
      r = '0;
      r.status = lit_status;
    end
    response_q = {response_q, r};
  endtask

  task automatic rnd_issue(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] wv,
                           input logic lvl);
    issue(cmd, next_time(), wv, lvl, 1'b0, 8'h00);
    if (cmd != CMD_UNUSED) n_random++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (response_q.size() != 0) @(posedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic idx, input logic [APB_DW-1:0] wdata,
                          output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic idx, input logic [DUR_W-1:0] want);
    logic [APB_DW-1:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== APB_DW'(want)) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("register %0d readback: expected %h, got %h", idx, APB_DW'(want), rd);
    end
  endtask

  // upper pwdata bits are junk on purpose; only 20 bits are kept
  task automatic set_duration(input logic idx, input logic [DUR_W-1:0] val);
    logic [APB_DW-1:0] rd;
    apb_xfer(1'b1, idx, {12'($urandom), val}, rd);
    if (idx == REG_BUSY_DUR) dur_busy = val;
    else dur_ack = val;
    check_reg(idx, val);
  endtask

  task automatic random_phase(input int n_items);
    int start;
    int pick;
    start = n_random;
    while (n_random - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        // print one byte, then poll
        if (!online_q && $urandom_range(3) != 0) rnd_issue(CMD_ONLINE, 8'($urandom), 1'b1);
        if ($urandom_range(1)) rnd_issue(CMD_WR_DATA, 8'($urandom), 1'($urandom));
        rnd_issue(CMD_WR_CTRL, {2'b11, 6'($urandom)}, 1'($urandom));
        rnd_issue(CMD_WR_CTRL, {2'b01, 6'($urandom)}, 1'($urandom));
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(2))
            0: rnd_issue(CMD_READ, 8'($urandom), 1'($urandom));
            1: rnd_issue(CMD_TIME, 8'($urandom), 1'($urandom));
            default: rnd_issue(CMD_TAKE_IRQ, 8'($urandom), 1'($urandom));
          endcase
        end
      end else if (pick < 70) begin
        rnd_issue(CMD_WR_CTRL, {1'($urandom), 1'b0, 6'($urandom)}, 1'($urandom));
        rnd_issue(CMD_WR_CTRL, {2'b11, 6'($urandom)}, 1'($urandom));
      end else if (pick < 75) begin
        rnd_issue(CMD_ONLINE, 8'($urandom), 1'($urandom));
      end else if (pick < 78) begin
        rnd_issue(CMD_CLEAR, 8'($urandom), 1'($urandom));
      end else if (pick < 79) begin
        drain();
      end else begin
        rnd_issue(3'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
                         input logic [BYTE_W-1:0] wv, input logic lvl,
                         input bit lit, input logic [BYTE_W-1:0] lit_status);
    stim_row_t row;
    row.c.cmd = cmd;
    row.c.t   = t;
    row.c.wv  = wv;
    row.c.lvl = lvl;
    row.lit   = lit;
    row.lit_status = lit_status;
    stim_table = {stim_table, row};
  endtask

  always @(posedge clk) m_tready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin : result_check
    port_resp_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (response_q.size() == 0) begin
        n_unexpected++;
        if (n_unexpected <= 10) $display("unexpected response: %s", fmt_resp(got));
      end else begin
        want = response_q.pop_front();
        n_checked++;
        if (got.status !== want.status || got.irq !== want.irq || got.acc !== want.acc ||
            got.abyte !== want.abyte || got.fill !== want.fill ||
            got.drops !== want.drops || got.dirty !== want.dirty) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("response %0d mismatch: expected %s, got %s",
                     n_checked, fmt_resp(want), fmt_resp(got));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : main
    int leftover;
    // directed rows: reset status, unused code, a full print handshake with IRQ,
    // PRIM drop, offline strobe, deadline wrap, time stepping back, clear
    add_row(CMD_READ,     64'd0,    8'h00, 1'b0, 1'b1, 8'hCE);
    add_row(CMD_UNUSED,   64'd0,    8'hFF, 1'b1, 1'b1, 8'h00);
    add_row(CMD_WR_DATA,  64'd1,    8'h00, 1'b0, 1'b0, 8'h00);
    add_row(CMD_WR_CTRL,  64'd2,    8'hC0, 1'b0, 1'b0, 8'h00);
    add_row(CMD_WR_CTRL,  64'd3,    8'h40, 1'b0, 1'b0, 8'h00);
    add_row(CMD_READ,     64'd4,    8'h00, 1'b0, 1'b0, 8'h00);
    add_row(CMD_TIME,     64'd1003, 8'h00, 1'b0, 1'b0, 8'h00);
    add_row(CMD_READ,     64'd1003, 8'h00, 1'b0, 1'b0, 8'h00);
    add_row(CMD_TAKE_IRQ, 64'd1003, 8'h00, 1'b0, 1'b0, 8'h00);
    add_row(CMD_TAKE_IRQ, 64'd1003, 8'h00, 1'b0, 1'b0, 8'h00);
    add_row(CMD_TIME,     64'd1103, 8'h00, 1'b0, 1'b0, 8'h00);
    add_row(CMD_WR_DATA,  64'd1200, 8'hFF, 1'b1, 1'b0, 8'h00);
    add_row(CMD_WR_CTRL,  64'd1200, 8'hC0, 1'b0, 1'b0, 8'h00);
    add_row(CMD_WR_CTRL,  64'd1201, 8'h00, 1'b0, 1'b0, 8'h00);
    add_row(CMD_WR_CTRL,  64'd1202, 8'hFF, 1'b0, 1'b0, 8'h00);
    add_row(CMD_ONLINE,   64'd1203, 8'h00, 1'b0, 1'b0, 8'h00);
    add_row(CMD_WR_CTRL,  64'd1204, 8'h7F, 1'b0, 1'b0, 8'h00);
    add_row(CMD_READ,     64'd1205, 8'h00, 1'b0, 1'b0, 8'h00);
    add_row(CMD_ONLINE,   64'd1206, 8'h00, 1'b1, 1'b0, 8'h00);
    add_row(CMD_WR_CTRL,  64'hFFFF_FFFF_FFFF_FE0C, 8'hC0, 1'b0, 1'b0, 8'h00);
    add_row(CMD_WR_CTRL,  64'hFFFF_FFFF_FFFF_FE0C, 8'h40, 1'b0, 1'b0, 8'h00);
    add_row(CMD_TIME,     64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00);
    add_row(CMD_READ,     64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00);
    add_row(CMD_TIME,     64'd5,    8'h00, 1'b0, 1'b0, 8'h00);
    add_row(CMD_CLEAR,    64'd5,    8'h00, 1'b0, 1'b1, 8'h00);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_reg(REG_BUSY_DUR, BUSY_DUR_RESET);
    check_reg(REG_ACK_DUR, ACK_DUR_RESET);

    foreach (stim_table[i])
      issue(stim_table[i].c.cmd, stim_table[i].c.t, stim_table[i].c.wv,
            stim_table[i].c.lvl, stim_table[i].lit, stim_table[i].lit_status);
    clock_now = 64'd5;

    tx_idle_pct = 15;
    rx_idle_pct = 87;
    drain();
    set_duration(REG_BUSY_DUR, 20'($urandom_range(5, 60)));
    set_duration(REG_ACK_DUR, 20'($urandom_range(1, 30)));
    random_phase(PHASE_ITEMS);

    tx_idle_pct = 87;
    rx_idle_pct = 15;
    drain();
    set_duration(REG_BUSY_DUR, '0);
    set_duration(REG_ACK_DUR, '0);
    random_phase(PHASE_ITEMS);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    drain();
    set_duration(REG_BUSY_DUR, '1);
    set_duration(REG_ACK_DUR, '1);
    random_phase(PHASE_ITEMS);

    // fill the capture buffer, then keep strobing into a full buffer
    drain();
    set_duration(REG_BUSY_DUR, '0);
    set_duration(REG_ACK_DUR, 20'($urandom_range(0, 40)));
    if (&clock_now[63:32]) clock_now = '0;
    issue(CMD_WR_CTRL, clock_now, 8'h00, 1'b0, 1'b0, 8'h00);
    issue(CMD_WR_CTRL, clock_now, 8'hC0, 1'b0, 1'b0, 8'h00);
    issue(CMD_ONLINE, clock_now, 8'h00, 1'b1, 1'b0, 8'h00);
    while (fill_q < BUF_DEPTH || drop_q < MIN_DROPS) begin
      if ($urandom_range(7) == 0)
        issue(CMD_WR_DATA, clock_now, 8'($urandom), 1'($urandom), 1'b0, 8'h00);
      clock_now = clock_now + $urandom_range(2);
      issue(CMD_WR_CTRL, clock_now, {2'b11, 6'($urandom)}, 1'($urandom), 1'b0, 8'h00);
      clock_now = clock_now + $urandom_range(2);
      issue(CMD_WR_CTRL, clock_now, {2'b01, 6'($urandom)}, 1'($urandom), 1'b0, 8'h00);
    end
    issue(CMD_CLEAR, clock_now, 8'h00, 1'b0, 1'b0, 8'h00);
    issue(CMD_READ, clock_now, 8'h00, 1'b0, 1'b0, 8'h00);

    drain();
    repeat (10) @(posedge clk);
    leftover = response_q.size();
    $display("Checked %0d responses over %0d random commands: %0d bytes strobed,",
             n_checked, n_random, n_strobes);
    $display("  %0d dropped on a full buffer, %0d interrupts taken; %0d mismatches",
             n_drops, n_irqs, n_mismatch);
    if (n_mismatch == 0 && n_unexpected == 0 && leftover == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
